// ----- hw/rtl/pid_motor_drive_controller_assert.svh -----
// Assertion macros shared by the motor drive controller modules.
`ifndef PID_MOTOR_DRIVE_CONTROLLER_ASSERT_SVH
`define PID_MOTOR_DRIVE_CONTROLLER_ASSERT_SVH
`ifndef ASSERT_OFF
// A condition that must hold at every clock edge out of reset.
`define PMDC_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("pmdc check failed");
// A condition that must hold in the cycle after its trigger.
`define PMDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmdc sequence check failed");
`else
`define PMDC_ASSERT(lbl, expr)
`define PMDC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/pmdc_pkg.sv -----
// Shared types and constants of the PID motor drive controller.
package pmdc_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int DRIVE_MAX   = 4000;
    localparam int DRIVE_W     = 12;
    localparam int LIMIT_W     = 31;
    localparam int TICK_W      = 16;
    localparam int TERM_W      = 2 * VALUE_WIDTH - FRAC_BITS;
    localparam int ACC_W       = TERM_W + 2;
    localparam int SDRIVE_W    = DRIVE_W + 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 48;
    localparam int FIFO_DEPTH  = 4;

    typedef enum logic [1:0] {
        MODE_OPEN_LOOP = 2'd0,
        MODE_POSITION  = 2'd1,
        MODE_VELOCITY  = 2'd2,
        MODE_CURRENT   = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CONTROL_MODE   = 3'd0,
        REG_PROP_GAIN      = 3'd1,
        REG_INTEGRAL_GAIN  = 3'd2,
        REG_DERIV_GAIN     = 3'd3,
        REG_ERR_SUM_LIMIT  = 3'd4,
        REG_POS_DRIVE_LIM  = 3'd5,
        REG_NEG_DRIVE_LIM  = 3'd6,
        REG_LINK_TIMEOUT   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        mode_t                          control_mode;
        logic signed [VALUE_WIDTH-1:0]  prop_gain;
        logic signed [VALUE_WIDTH-1:0]  integral_gain_dt;
        logic signed [VALUE_WIDTH-1:0]  deriv_gain_over_dt;
        logic [LIMIT_W-1:0]             error_sum_limit;
        logic [DRIVE_W-1:0]             positive_drive_limit;
        logic [DRIVE_W-1:0]             negative_drive_limit;
        logic [TICK_W-1:0]              link_timeout_ticks;
    } cfg_t;

    // One classified tick handed from the front end to the arithmetic back end.
    typedef struct packed {
        mode_t                          mode;
        logic                           link_lost;
        logic signed [VALUE_WIDTH-1:0]  reference;
        logic signed [VALUE_WIDTH-1:0]  feedback;
        logic signed [VALUE_WIDTH-1:0]  error;
        logic signed [VALUE_WIDTH-1:0]  error_sum;
        logic signed [VALUE_WIDTH-1:0]  delta;
    } work_t;

endpackage

// ----- hw/rtl/pmdc_front.sv -----
// Front end: takes each tick, updates loop history and the link timeout.
module pmdc_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  pmdc_pkg::cfg_t                         cfg,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [pmdc_pkg::VALUE_WIDTH-1:0] in_reference,
    input  logic signed [pmdc_pkg::VALUE_WIDTH-1:0] in_position,
    input  logic signed [pmdc_pkg::VALUE_WIDTH-1:0] in_velocity,
    input  logic                                   in_link_alive,
    input  logic                                   in_clear_history,
    output logic                                   push_valid,
    input  logic                                   push_ready,
    output pmdc_pkg::work_t                        push_data
);

    localparam int VW = pmdc_pkg::VALUE_WIDTH;

    logic signed [VW-1:0]               error_sum_reg;
    logic signed [VW-1:0]               error_sum_next;
    logic signed [VW-1:0]               prev_error_reg;
    logic [pmdc_pkg::TICK_W-1:0]        timeout_count_reg;
    logic [pmdc_pkg::TICK_W-1:0]        timeout_count_next;

    logic                               accept;
    logic [pmdc_pkg::TICK_W-1:0]        count_base;
    logic signed [VW-1:0]               sum_base;
    logic signed [VW-1:0]               prev_base;
    logic signed [VW-1:0]               feedback;
    logic signed [VW:0]                 err_wide;
    logic signed [VW-1:0]               err;
    logic signed [VW:0]                 sum_wide;
    logic signed [VW:0]                 limit_pos;
    logic signed [VW:0]                 limit_neg;
    logic signed [VW:0]                 delta_wide;
    logic signed [VW-1:0]               delta;
    logic                               lost;

    function automatic logic signed [VW-1:0] sat_narrow(input logic signed [VW:0] x);
        logic signed [VW-1:0] r;
        if (x[VW] != x[VW-1])
        begin
            r = x[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end
        else
        begin
            r = x[VW-1:0];
        end
        return r;
    endfunction

    assign accept     = in_valid && push_ready;
    assign in_ready   = push_ready;
    assign push_valid = in_valid;

    always_comb
    begin
        count_base = in_link_alive ? '0 : timeout_count_reg;
        if (count_base != {pmdc_pkg::TICK_W{1'b1}})
        begin
            timeout_count_next = count_base + 1'b1;
        end
        else
        begin
            timeout_count_next = count_base;
        end
        lost = timeout_count_next >= cfg.link_timeout_ticks;

        sum_base  = in_clear_history ? '0 : error_sum_reg;
        prev_base = in_clear_history ? '0 : prev_error_reg;

        if (cfg.control_mode == pmdc_pkg::MODE_OPEN_LOOP ||
            cfg.control_mode == pmdc_pkg::MODE_VELOCITY)
        begin
            feedback = in_velocity;
        end
        else
        begin
            feedback = in_position;
        end

        err_wide = (VW+1)'(in_reference) - (VW+1)'(feedback);
        err      = sat_narrow(err_wide);

        // The sum is clamped symmetrically; the limit always fits the value width.
        sum_wide  = (VW+1)'(sum_base) + (VW+1)'(err);
        limit_pos = $signed({{(VW+1-pmdc_pkg::LIMIT_W){1'b0}}, cfg.error_sum_limit});
        limit_neg = -limit_pos;
        if (sum_wide > limit_pos)
        begin
            error_sum_next = limit_pos[VW-1:0];
        end
        else if (sum_wide < limit_neg)
        begin
            error_sum_next = limit_neg[VW-1:0];
        end
        else
        begin
            error_sum_next = sum_wide[VW-1:0];
        end

        delta_wide = (VW+1)'(err) - (VW+1)'(prev_base);
        delta      = sat_narrow(delta_wide);
    end

    always_comb
    begin
        push_data.mode      = cfg.control_mode;
        push_data.link_lost = lost;
        push_data.reference = in_reference;
        push_data.feedback  = feedback;
        push_data.error     = err;
        push_data.error_sum = error_sum_next;
        push_data.delta     = delta;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg     <= '0;
            prev_error_reg    <= '0;
            timeout_count_reg <= '0;
        end
        else if (accept)
        begin
            error_sum_reg     <= error_sum_next;
            prev_error_reg    <= err;
            timeout_count_reg <= timeout_count_next;
        end
    end

`include "pid_motor_drive_controller_assert.svh"

    `PMDC_ASSERT_NEXT(a_front_tick_counted, accept, timeout_count_reg != '0)

endmodule

// ----- hw/rtl/pmdc_fifo.sv -----
// Short queue of classified ticks between the front and back ends.
module pmdc_fifo #(
    parameter int DEPTH = pmdc_pkg::FIFO_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  pmdc_pkg::work_t   push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output pmdc_pkg::work_t   pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pmdc_pkg::work_t    entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

`include "pid_motor_drive_controller_assert.svh"

    `PMDC_ASSERT(a_fifo_bounded, count_reg <= CNT_W'(DEPTH))
    `PMDC_ASSERT_NEXT(a_fifo_fill, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// ----- hw/rtl/pmdc_back.sv -----
// Back end: gain products, term sum, drive clamps and the output register.
module pmdc_back (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  pmdc_pkg::cfg_t                          cfg,
    input  logic                                    pop_valid,
    output logic                                    pop_ready,
    input  pmdc_pkg::work_t                         pop_data,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [pmdc_pkg::DRIVE_W-1:0]            drive_magnitude,
    output logic                                    drive_direction,
    output logic                                    link_lost,
    output logic signed [pmdc_pkg::VALUE_WIDTH-1:0] feedback_value
);

    localparam int VW  = pmdc_pkg::VALUE_WIDTH;
    localparam int FB  = pmdc_pkg::FRAC_BITS;
    localparam int TW  = pmdc_pkg::TERM_W;
    localparam int AW  = pmdc_pkg::ACC_W;
    localparam int DW  = pmdc_pkg::DRIVE_W;
    localparam int SW  = pmdc_pkg::SDRIVE_W;
    localparam logic signed [SW-1:0] DRV_MAX_POS = SW'(pmdc_pkg::DRIVE_MAX);
    localparam logic signed [SW-1:0] DRV_MAX_NEG = -DRV_MAX_POS;

    // Stage one: products.
    logic                       s1_valid_reg;
    logic signed [2*VW-1:0]     p_prod_reg;
    logic signed [2*VW-1:0]     i_prod_reg;
    logic signed [2*VW-1:0]     d_prod_reg;
    logic signed [VW-1:0]       s1_ref_reg;
    logic signed [VW-1:0]       s1_fb_reg;
    pmdc_pkg::mode_t            s1_mode_reg;
    logic                       s1_lost_reg;

    // Stage two: accumulated control value.
    logic                       s2_valid_reg;
    logic signed [AW-1:0]       acc_reg;
    logic signed [AW-1:0]       acc_next;
    logic signed [VW-1:0]       s2_fb_reg;
    logic                       s2_lost_reg;

    // Output register.
    logic                       out_valid_reg;
    logic [DW-1:0]              drive_mag_reg;
    logic [DW-1:0]              drive_mag_next;
    logic                       drive_dir_reg;
    logic                       drive_dir_next;
    logic                       lost_reg;
    logic signed [VW-1:0]       fb_reg;

    logic                       adv_out;
    logic                       adv2;
    logic                       adv1;

    logic signed [TW-1:0]       p_term;
    logic signed [TW-1:0]       i_term;
    logic signed [TW-1:0]       d_term;
    logic signed [AW-1:0]       pos_th;
    logic signed [AW-1:0]       neg_th;
    logic signed [AW-1:0]       acc_bias;
    logic signed [AW-1:0]       acc_cut;
    logic signed [SW-1:0]       drive_lim;
    logic signed [SW-1:0]       drive_fin;
    logic signed [SW-1:0]       drive_abs;

    assign adv_out   = !out_valid_reg || out_ready;
    assign adv2      = !s2_valid_reg || adv_out;
    assign adv1      = !s1_valid_reg || adv2;
    assign pop_ready = adv1;

    always_comb
    begin
        p_term = p_prod_reg[2*VW-1:FB];
        i_term = i_prod_reg[2*VW-1:FB];
        d_term = d_prod_reg[2*VW-1:FB];
        acc_next = AW'(p_term) + AW'(i_term) + AW'(d_term);
        if (s1_lost_reg && (s1_mode_reg == pmdc_pkg::MODE_VELOCITY ||
                            s1_mode_reg == pmdc_pkg::MODE_CURRENT))
        begin
            acc_next = '0;
        end
        if (s1_mode_reg == pmdc_pkg::MODE_OPEN_LOOP)
        begin
            acc_next = AW'(s1_ref_reg);
        end
    end

    always_comb
    begin
        pos_th = $signed({{(AW-DW-FB){1'b0}}, cfg.positive_drive_limit, {FB{1'b0}}});
        neg_th = -$signed({{(AW-DW-FB){1'b0}}, cfg.negative_drive_limit, {FB{1'b0}}});
        // Negative values are cut towards zero by biasing before the shift.
        acc_bias = acc_reg + $signed({{(AW-FB){1'b0}}, {FB{1'b1}}});
        acc_cut  = acc_reg[AW-1] ? acc_bias : acc_reg;

        priority if (acc_reg > pos_th)
        begin
            drive_lim = $signed({2'b00, cfg.positive_drive_limit});
        end
        else if (acc_reg < neg_th)
        begin
            drive_lim = -$signed({2'b00, cfg.negative_drive_limit});
        end
        else
        begin
            drive_lim = acc_cut[FB+SW-1:FB];
        end

        priority if (drive_lim > DRV_MAX_POS)
        begin
            drive_fin = DRV_MAX_POS;
        end
        else if (drive_lim < DRV_MAX_NEG)
        begin
            drive_fin = DRV_MAX_NEG;
        end
        else
        begin
            drive_fin = drive_lim;
        end

        drive_abs      = drive_fin[SW-1] ? -drive_fin : drive_fin;
        drive_mag_next = drive_abs[DW-1:0];
        drive_dir_next = drive_fin[SW-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && pop_valid)
        begin
            p_prod_reg  <= pop_data.error * cfg.prop_gain;
            i_prod_reg  <= pop_data.error_sum * cfg.integral_gain_dt;
            d_prod_reg  <= pop_data.delta * cfg.deriv_gain_over_dt;
            s1_ref_reg  <= pop_data.reference;
            s1_fb_reg   <= pop_data.feedback;
            s1_mode_reg <= pop_data.mode;
            s1_lost_reg <= pop_data.link_lost;
        end
        if (adv2 && s1_valid_reg)
        begin
            acc_reg     <= acc_next;
            s2_fb_reg   <= s1_fb_reg;
            s2_lost_reg <= s1_lost_reg;
        end
        if (adv_out && s2_valid_reg)
        begin
            drive_mag_reg <= drive_mag_next;
            drive_dir_reg <= drive_dir_next;
            lost_reg      <= s2_lost_reg;
            fb_reg        <= s2_fb_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= pop_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv_out)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign drive_magnitude = drive_mag_reg;
    assign drive_direction = drive_dir_reg;
    assign link_lost       = lost_reg;
    assign feedback_value  = fb_reg;

`include "pid_motor_drive_controller_assert.svh"

    `PMDC_ASSERT(a_back_mag_range, !out_valid_reg || drive_mag_reg <= DW'(pmdc_pkg::DRIVE_MAX))
    `PMDC_ASSERT(a_back_dir_nonzero, !(out_valid_reg && drive_dir_reg) || drive_mag_reg != '0)

endmodule

// ----- hw/rtl/pid_motor_drive_controller.sv -----
// A word accepted on s_tdata passes the queue, products, sum and clamp stages, each registered,
// to m_tdata; it waits while the queue holds older words or the output is not taken.
// Throughput: one word per cycle while the queue has room; history updates as each word is accepted.
// The four-entry queue lets the front keep accepting while the output side is stalled.
// Reset (rst_n low, asynchronous) clears history, timeout count and queue, and loads the
// register defaults: open loop, zero gains, drive limits 4000, link timeout 65535.
module pid_motor_drive_controller #(
    parameter int FIFO_DEPTH = pmdc_pkg::FIFO_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // reference[31:0], measured_position[63:32], measured_velocity[95:64],
    // link_alive[96], clear_history[97], zero fill[103:98]
    input  logic [pmdc_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // drive_magnitude[11:0], drive_direction[12], link_lost[13],
    // feedback_value[45:14], zero fill[47:46]
    output logic [pmdc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pmdc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pmdc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int VW = pmdc_pkg::VALUE_WIDTH;
    localparam int DW = pmdc_pkg::DRIVE_W;

    pmdc_pkg::cfg_t         cfg_reg;
    pmdc_pkg::work_t        push_data;
    pmdc_pkg::work_t        pop_data;
    logic                   push_valid;
    logic                   push_ready;
    logic                   pop_valid;
    logic                   pop_ready;
    logic [DW-1:0]          drive_magnitude;
    logic                   drive_direction;
    logic                   link_lost;
    logic signed [VW-1:0]   feedback_value;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.control_mode         <= pmdc_pkg::MODE_OPEN_LOOP;
            cfg_reg.prop_gain            <= '0;
            cfg_reg.integral_gain_dt     <= '0;
            cfg_reg.deriv_gain_over_dt   <= '0;
            cfg_reg.error_sum_limit      <= '0;
            cfg_reg.positive_drive_limit <= DW'(pmdc_pkg::DRIVE_MAX);
            cfg_reg.negative_drive_limit <= DW'(pmdc_pkg::DRIVE_MAX);
            cfg_reg.link_timeout_ticks   <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (pmdc_pkg::reg_idx_t'(cfg_index))
                pmdc_pkg::REG_CONTROL_MODE:
                    cfg_reg.control_mode <= pmdc_pkg::mode_t'(cfg_data[1:0]);
                pmdc_pkg::REG_PROP_GAIN:
                    cfg_reg.prop_gain <= cfg_data[VW-1:0];
                pmdc_pkg::REG_INTEGRAL_GAIN:
                    cfg_reg.integral_gain_dt <= cfg_data[VW-1:0];
                pmdc_pkg::REG_DERIV_GAIN:
                    cfg_reg.deriv_gain_over_dt <= cfg_data[VW-1:0];
                pmdc_pkg::REG_ERR_SUM_LIMIT:
                    cfg_reg.error_sum_limit <= cfg_data[pmdc_pkg::LIMIT_W-1:0];
                pmdc_pkg::REG_POS_DRIVE_LIM:
                    cfg_reg.positive_drive_limit <= cfg_data[DW-1:0];
                pmdc_pkg::REG_NEG_DRIVE_LIM:
                    cfg_reg.negative_drive_limit <= cfg_data[DW-1:0];
                pmdc_pkg::REG_LINK_TIMEOUT:
                    cfg_reg.link_timeout_ticks <= cfg_data[pmdc_pkg::TICK_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    pmdc_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_reference     (s_tdata[VW-1:0]),
        .in_position      (s_tdata[2*VW-1:VW]),
        .in_velocity      (s_tdata[3*VW-1:2*VW]),
        .in_link_alive    (s_tdata[3*VW]),
        .in_clear_history (s_tdata[3*VW+1]),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_data        (push_data)
    );

    pmdc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    pmdc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_data        (pop_data),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .drive_magnitude (drive_magnitude),
        .drive_direction (drive_direction),
        .link_lost       (link_lost),
        .feedback_value  (feedback_value)
    );

    assign m_tdata = {2'b00, feedback_value, link_lost, drive_direction, drive_magnitude};

endmodule
